@@ hw/rtl/brf_pkg.sv @@
// Shared types and constants for the reflective box fold pipeline.
// Used by brf_prep, brf_rem_stage, brf_fold_post and box_reflect_fold_core.
package brf_pkg;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned MAG_W     = DATA_W + 1;   // |position - lower| fits here
    localparam int unsigned PERIOD_W  = DATA_W + 1;   // twice the width
    localparam int unsigned MIRROR_W  = DATA_W + 2;   // 2*bound - position
    localparam int unsigned REM_STEPS = MAG_W;        // one remainder bit per stage

    typedef enum logic [2:0] {
        KIND_PASS,
        KIND_BAD,
        KIND_CLAMP,
        KIND_FOLD,
        KIND_MIRROR_LO,
        KIND_MIRROR_HI
    } fold_kind_t;

    // Item as it travels through the remainder stages
    typedef struct packed {
        fold_kind_t                  kind;
        logic signed [DATA_W-1:0]    pos;
        logic signed [DATA_W-1:0]    lo;
        logic signed [DATA_W-1:0]    hi;
        logic        [DATA_W-1:0]    width;
        logic        [PERIOD_W-1:0]  period;
        logic                        neg;
        logic        [MAG_W-1:0]     mag;
        logic        [PERIOD_W-1:0]  rem;
    } rem_item_t;

    // Item ready for the final select
    typedef struct packed {
        fold_kind_t                  kind;
        logic signed [DATA_W-1:0]    pos;
        logic signed [DATA_W-1:0]    lo;
        logic        [PERIOD_W-1:0]  offset;
        logic                        rev;
        logic signed [MIRROR_W-1:0]  mirror;
    } post_item_t;

endpackage

@@ hw/rtl/box_reflect_fold_core.sv @@
// Top level of the reflective box fold: folds a Q16.16 coordinate into its box.
// Instantiates brf_prep, brf_rem_stage, brf_fold_post; depends on brf_pkg.
//
// Input stream (s_*): one coordinate with its bounds per transfer; the two
// unbounded flags travel in s_tuser. Output stream (m_*): the folded
// coordinate in m_tdata, reverse_momentum and bad_bounds in m_tuser.
// Exactly one output transfer follows each input transfer, in order.
//
// There are 37 register stages (one classify stage, 33 remainder stages at one
// quotient bit each, two fix-up stages and the output register); the classify
// stage loads at the edge of the input transfer. The bit-serial restoring
// remainder sets the depth.
// Throughput: one transfer per cycle while no stall holds the pipeline.
//
// Stall: when m_tready is low with a result waiting, the pipeline still
// advances as long as the stage in front of the output register is empty,
// so bubbles close up; otherwise every stage holds and s_tready drops.
// Reset clears all valid bits; nothing is in flight afterwards.
module box_reflect_fold_core (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [95:0]  s_tdata,   // position[31:0], lower_bound[63:32], upper_bound[95:64]
    input  logic [1:0]   s_tuser,   // lower_unbounded[0], upper_unbounded[1]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // folded_position[31:0]
    output logic [1:0]   m_tuser    // reverse_momentum[0], bad_bounds[1]
);
    import brf_pkg::*;

    logic                       adv;
    logic                       out_load;
    logic                       stage_valid [REM_STEPS+1];
    rem_item_t                  stage_item  [REM_STEPS+1];
    logic                       post_valid;
    post_item_t                 post_item;
    logic                       out_valid_reg;
    logic [DATA_W-1:0]          out_data_reg;
    logic [DATA_W-1:0]          out_data_next;
    logic                       out_rev_reg;
    logic                       out_rev_next;
    logic                       out_bad_reg;
    logic                       out_bad_next;
    logic signed [MIRROR_W-1:0] fold_sum;

    assign out_load = m_tready || !out_valid_reg;
    assign adv      = out_load || !post_valid;
    assign s_tready = adv;

    brf_prep u_prep (
        .clk             (clk),
        .rst_n           (rst_n),
        .en              (adv),
        .in_valid        (s_tvalid),
        .position        (s_tdata[31:0]),
        .lower_bound     (s_tdata[63:32]),
        .upper_bound     (s_tdata[95:64]),
        .lower_unbounded (s_tuser[0]),
        .upper_unbounded (s_tuser[1]),
        .out_valid       (stage_valid[0]),
        .out_item        (stage_item[0])
    );

    // Dividend bits taken most significant first
    for (genvar k = 0; k < REM_STEPS; k++)
    begin : g_rem
        brf_rem_stage #(
            .BIT_IDX (REM_STEPS - 1 - k)
        ) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .in_valid  (stage_valid[k]),
            .in_item   (stage_item[k]),
            .out_valid (stage_valid[k+1]),
            .out_item  (stage_item[k+1])
        );
    end

    brf_fold_post u_post (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (stage_valid[REM_STEPS]),
        .in_item   (stage_item[REM_STEPS]),
        .out_valid (post_valid),
        .out_item  (post_item)
    );

    assign fold_sum = {{2{post_item.lo[DATA_W-1]}}, post_item.lo} + {1'b0, post_item.offset};

    always_comb
    begin
        out_data_next = post_item.pos;
        out_rev_next  = 1'b0;
        out_bad_next  = 1'b0;
        case (post_item.kind) inside
            KIND_BAD:
                out_bad_next = 1'b1;
            KIND_CLAMP:
                out_data_next = post_item.lo;
            KIND_FOLD:
            begin
                out_data_next = fold_sum[DATA_W-1:0];
                out_rev_next  = post_item.rev;
            end
            KIND_MIRROR_LO, KIND_MIRROR_HI:
            begin
                out_rev_next = 1'b1;
                // Saturate the single mirror to the 32-bit range
                if (post_item.mirror > MIRROR_W'(signed'(32'sh7FFF_FFFF)))
                    out_data_next = 32'h7FFF_FFFF;
                else if (post_item.mirror < MIRROR_W'(signed'(32'sh8000_0000)))
                    out_data_next = 32'h8000_0000;
                else
                    out_data_next = post_item.mirror[DATA_W-1:0];
            end
            default:
                out_data_next = post_item.pos;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= post_valid;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_data_next;
            out_rev_reg  <= out_rev_next;
            out_bad_reg  <= out_bad_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_bad_reg, out_rev_reg};

    // Bad bounds never come with a reflection
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tuser[0] && m_tuser[1]))
        else $error("bad_bounds and reverse_momentum both set");

    // A full stage behind a stalled output must freeze the pipeline
    a_stall_freezes: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready && post_valid) |-> !adv)
        else $error("pipeline advanced into a stalled output");

    // Folded offset never exceeds the box width, so the sum stays in range
    a_fold_offset: assert property (@(posedge clk) disable iff (!rst_n)
        (post_valid && post_item.kind == KIND_FOLD) |-> !post_item.offset[PERIOD_W-1])
        else $error("fold offset beyond box width");

    // A result leaves the output register only through a transfer
    a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> m_tvalid)
        else $error("pending result dropped");

endmodule

@@ hw/rtl/brf_prep.sv @@
// Entry stage: classifies the point against the bounds and sets up the remainder.
// Depends on brf_pkg.
module brf_prep (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic signed [31:0]                position,
    input  logic signed [31:0]                lower_bound,
    input  logic signed [31:0]                upper_bound,
    input  logic                              lower_unbounded,
    input  logic                              upper_unbounded,
    output logic                              out_valid,
    output brf_pkg::rem_item_t                out_item
);
    import brf_pkg::*;

    logic                       valid_reg;
    rem_item_t                  item_reg;
    rem_item_t                  item_next;
    logic                       below;
    logic                       above;
    logic signed [MAG_W-1:0]    diff;

    assign below = !lower_unbounded && (position < lower_bound);
    assign above = !upper_unbounded && (position > upper_bound);
    assign diff  = MAG_W'(position) - MAG_W'(lower_bound);

    always_comb
    begin
        item_next        = '0;
        item_next.pos    = position;
        item_next.lo     = lower_bound;
        item_next.hi     = upper_bound;
        item_next.width  = DATA_W'(upper_bound - lower_bound);
        item_next.period = {item_next.width, 1'b0};
        item_next.neg    = diff[MAG_W-1];
        item_next.mag    = diff[MAG_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
        item_next.rem    = '0;
        if (!lower_unbounded && !upper_unbounded)
        begin
            if (lower_bound > upper_bound)
                item_next.kind = KIND_BAD;
            else if (below || above)
                item_next.kind = (lower_bound == upper_bound) ? KIND_CLAMP : KIND_FOLD;
            else
                item_next.kind = KIND_PASS;
        end
        else if (below)
            item_next.kind = KIND_MIRROR_LO;
        else if (above)
            item_next.kind = KIND_MIRROR_HI;
        else
            item_next.kind = KIND_PASS;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hw/rtl/brf_rem_stage.sv @@
// One restoring step of the remainder |position - lower| mod period.
// Depends on brf_pkg.
module brf_rem_stage #(
    parameter int unsigned BIT_IDX = 0
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  brf_pkg::rem_item_t   in_item,
    output logic                 out_valid,
    output brf_pkg::rem_item_t   out_item
);
    import brf_pkg::*;

    logic                   valid_reg;
    rem_item_t              item_reg;
    rem_item_t              item_next;
    logic [PERIOD_W:0]      trial;

    // Bring down the next dividend bit, subtract the period if it fits
    assign trial = {in_item.rem, in_item.mag[BIT_IDX]};

    always_comb
    begin
        item_next = in_item;
        if (trial >= {1'b0, in_item.period})
            item_next.rem = PERIOD_W'(trial - {1'b0, in_item.period});
        else
            item_next.rem = PERIOD_W'(trial);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else if (en)
            valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
            item_reg <= item_next;
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ hw/rtl/brf_fold_post.sv @@
// Two stages after the remainder: sign fix-up, then mirror about the upper bound.
// Also forms 2*bound - position for the one-sided cases. Depends on brf_pkg.
module brf_fold_post (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  brf_pkg::rem_item_t   in_item,
    output logic                 out_valid,
    output brf_pkg::post_item_t  out_item
);
    import brf_pkg::*;

    logic                        fix_valid_reg;
    rem_item_t                   fix_item_reg;
    rem_item_t                   fix_item_next;
    logic                        valid_reg;
    post_item_t                  item_reg;
    post_item_t                  item_next;
    logic signed [MIRROR_W-1:0]  twice_bound;

    // Negative offset: nonzero remainder wraps to period - rem
    always_comb
    begin
        fix_item_next = in_item;
        if (in_item.neg && (in_item.rem != '0))
            fix_item_next.rem = in_item.period - in_item.rem;
    end

    always_comb
    begin
        if (fix_item_reg.kind == KIND_MIRROR_LO)
            twice_bound = {fix_item_reg.lo[DATA_W-1], fix_item_reg.lo, 1'b0};
        else
            twice_bound = {fix_item_reg.hi[DATA_W-1], fix_item_reg.hi, 1'b0};
        item_next        = '0;
        item_next.kind   = fix_item_reg.kind;
        item_next.pos    = fix_item_reg.pos;
        item_next.lo     = fix_item_reg.lo;
        item_next.mirror = twice_bound - MIRROR_W'(fix_item_reg.pos);
        if (fix_item_reg.rem > {1'b0, fix_item_reg.width})
        begin
            item_next.offset = fix_item_reg.period - fix_item_reg.rem;
            item_next.rev    = 1'b1;
        end
        else
        begin
            item_next.offset = fix_item_reg.rem;
            item_next.rev    = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fix_valid_reg <= 1'b0;
            valid_reg     <= 1'b0;
        end
        else if (en)
        begin
            fix_valid_reg <= in_valid;
            valid_reg     <= fix_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fix_item_reg <= fix_item_next;
            item_reg     <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

@@ test/box_reflect_fold_core_tb.sv @@
`timescale 1ns / 1ps
// Self-checking bench for box_reflect_fold_core: streams coordinates with their bounds,
// predicts each folded result and compares it in order. Depends on brf_pkg and the core.
module box_reflect_fold_core_tb;

    import brf_pkg::DATA_W;

    localparam longint Q_MAX      = 64'sd2147483647;
    localparam longint Q_MIN      = -64'sd2147483648;
    localparam int     Q_ONE      = 32'sh0001_0000;
    localparam int     IDLE_PCT   = 34;
    localparam int     RAND_ITEMS = 550;
    localparam int     HOLD_LEN   = 150;
    localparam int     CYCLE_CAP  = 400000;

    typedef struct packed {
        logic signed [DATA_W-1:0] pos;
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        logic                     lo_inf;
        logic                     hi_inf;
    } coord_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] folded;
        logic                     rev;
        logic                     bad;
    } fold_t;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [95:0]  s_tdata = '0;    // position[31:0], lower_bound[63:32], upper_bound[95:64]
    logic [1:0]   s_tuser = '0;    // lower_unbounded[0], upper_unbounded[1]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [31:0]  m_tdata;         // folded_position[31:0]
    logic [1:0]   m_tuser;         // reverse_momentum[0], bad_bounds[1]

    coord_t coord_q[$];
    fold_t  fold_expect_q[$];
    coord_t cur_coord;
    int     accepted_cnt = 0;
    int     fail_cnt = 0;
    int     cycle_cnt = 0;
    int     hold_cnt = 0;
    logic   hold_done = 1'b0;
    logic   steady;

    box_reflect_fold_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // no idling on either side for a window in the middle of the random part
    assign steady = (accepted_cnt >= 250) && (accepted_cnt < 330);

    function automatic longint clamp_q(longint v);
        if (v > Q_MAX)
            return Q_MAX;
        if (v < Q_MIN)
            return Q_MIN;
        return v;
    endfunction

    function automatic fold_t fold_into_box(coord_t c);
        fold_t  f;
        longint x, lo, hi, w, p, r, res;
        logic   below, above;
        x = c.pos;
        lo = c.lo;
        hi = c.hi;
        res = x;
        f.rev = 1'b0;
        f.bad = 1'b0;
        below = !c.lo_inf && (x < lo);
        above = !c.hi_inf && (x > hi);
        if (!c.lo_inf && !c.hi_inf)
        begin
            if (lo > hi)
                f.bad = 1'b1;
            else if (below || above)
            begin
                w = hi - lo;
                p = 2 * w;
                if (p == 0)
                    res = lo;
                else
                begin
                    // nonnegative remainder within one period
                    r = (x - lo) % p;
                    if (r < 0)
                        r += p;
                    if (r > w)
                    begin
                        res = lo + p - r;
                        f.rev = 1'b1;
                    end
                    else
                        res = lo + r;
                end
            end
        end
        else if (below)
        begin
            res = clamp_q(2 * lo - x);
            f.rev = 1'b1;
        end
        else if (above)
        begin
            res = clamp_q(2 * hi - x);
            f.rev = 1'b1;
        end
        f.folded = res[DATA_W-1:0];
        return f;
    endfunction

    function automatic coord_t mk_coord(int pos, int lo, int hi, bit lo_inf, bit hi_inf);
        coord_t c;
        c.pos = pos;
        c.lo = lo;
        c.hi = hi;
        c.lo_inf = lo_inf;
        c.hi_inf = hi_inf;
        return c;
    endfunction

    function automatic coord_t random_coord();
        coord_t c;
        longint lo, hi, w, pos;
        int     sh;
        c.pos = $urandom;
        c.lo = $urandom;
        c.hi = $urandom;
        c.lo_inf = 1'($urandom_range(1));
        c.hi_inf = 1'($urandom_range(1));
        case ($urandom_range(9))
            2, 3, 4, 8, 9:
            begin
                // finite ordered box; point a few periods away or near an edge
                sh = $urandom_range(30);
                lo = int'($urandom);
                w = $urandom_range(32'd1 << sh);
                hi = clamp_q(lo + w);
                w = hi - lo;
                c.lo = lo[DATA_W-1:0];
                c.hi = hi[DATA_W-1:0];
                c.lo_inf = 1'b0;
                c.hi_inf = 1'b0;
                if ($urandom_range(3) == 0)
                    pos = ($urandom_range(1) ? hi : lo) + $urandom_range(8) - 4;
                else
                    pos = lo + longint'(int'($urandom_range(16)) - 8) * w
                        + longint'($urandom_range(32'(w)));
                c.pos = DATA_W'(clamp_q(pos));
            end
            5:
            begin
                c.lo_inf = 1'b0;
                c.hi_inf = 1'b0;
                if ($urandom_range(1))
                    c.hi = c.lo;
            end
            6, 7:
            begin
                // one side open
                c.lo_inf = 1'($urandom_range(1));
                c.hi_inf = !c.lo_inf;
            end
            default:
            begin
            end
        endcase
        return c;
    endfunction

    // sender: present a new transfer when the slot is free, idling at random outside the steady window
    always @(posedge clk)
    begin
        if (!rst_n)
            s_tvalid <= 1'b0;
        else
        begin
            if (s_tvalid && s_tready)
            begin
                fold_expect_q.push_back(fold_into_box(cur_coord));
                accepted_cnt <= accepted_cnt + 1;
            end
            if (!s_tvalid || s_tready)
            begin
                if (coord_q.size() > 0 && (steady || $urandom_range(99) >= IDLE_PCT))
                begin
                    cur_coord = coord_q.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata <= {cur_coord.hi, cur_coord.lo, cur_coord.pos};
                    s_tuser <= {cur_coord.hi_inf, cur_coord.lo_inf};
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // receiver: check each transfer, stall at random and once for a long stretch
    always @(posedge clk)
    begin
        fold_t want;
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (fold_expect_q.size() == 0)
                begin
                    $display("%0t: unexpected result folded_position %h tuser %b",
                             $time, m_tdata, m_tuser);
                    fail_cnt++;
                end
                else
                begin
                    want = fold_expect_q.pop_front();
                    if (m_tdata !== want.folded)
                    begin
                        $display("%0t: folded_position expected %h actual %h",
                                 $time, want.folded, m_tdata);
                        fail_cnt++;
                    end
                    if (m_tuser[0] !== want.rev)
                    begin
                        $display("%0t: reverse_momentum expected %b actual %b",
                                 $time, want.rev, m_tuser[0]);
                        fail_cnt++;
                    end
                    if (m_tuser[1] !== want.bad)
                    begin
                        $display("%0t: bad_bounds expected %b actual %b",
                                 $time, want.bad, m_tuser[1]);
                        fail_cnt++;
                    end
                end
            end
            if (hold_cnt > 0)
            begin
                hold_cnt <= hold_cnt - 1;
                m_tready <= 1'b0;
            end
            else if (!hold_done && accepted_cnt >= 400)
            begin
                hold_cnt <= HOLD_LEN;
                hold_done <= 1'b1;
                m_tready <= 1'b0;
            end
            else
                m_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_CAP)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic drain();
        @(negedge clk);
        while (coord_q.size() > 0 || s_tvalid || fold_expect_q.size() > 0)
            @(negedge clk);
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        coord_q.push_back(mk_coord(0, -Q_ONE, Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(32'h7fffffff, 0, 0, 1, 1));
        coord_q.push_back(mk_coord(32'h80000000, 0, 0, 1, 1));
        coord_q.push_back(mk_coord(-5 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(9 * Q_ONE, 3 * Q_ONE, 3 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(32'h80000000, 32'h7fffffff, 32'h7fffffff, 0, 0));
        coord_q.push_back(mk_coord(7, Q_ONE, -Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(2 * Q_ONE, Q_ONE, -Q_ONE, 1, 0));
        coord_q.push_back(mk_coord(-Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(-5 * Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(5 * Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(9 * Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(12 * Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(0, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(4 * Q_ONE, 0, 4 * Q_ONE, 0, 0));
        coord_q.push_back(mk_coord(32'h7fffffff, 32'h80000000, 32'h80000001, 0, 0));
        coord_q.push_back(mk_coord(32'h80000000, 32'h80000000, 32'h7fffffff, 0, 0));
        coord_q.push_back(mk_coord(32'h80000000, 32'h7fffffff, 0, 0, 1));
        coord_q.push_back(mk_coord(32'h7fffffff, 0, 32'h80000000, 1, 0));
        coord_q.push_back(mk_coord(0, Q_ONE, 0, 0, 1));
        coord_q.push_back(mk_coord(-3 * Q_ONE, 0, Q_ONE, 1, 0));
        coord_q.push_back(mk_coord(-1, -1, -1, 1, 1));
        coord_q.push_back(mk_coord(-1, 32'h7fffffff, 32'h80000000, 0, 0));
        drain();

        for (int i = 0; i < RAND_ITEMS; i++)
            coord_q.push_back(random_coord());
        drain();

        repeat (40) @(posedge clk);
        if (fail_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
